// ===== rtl/lgp_register_machine_executor_macros.svh =====
// ----------------------------------------------------------------------------
// Register machine executor assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LGP_REGISTER_MACHINE_EXECUTOR_MACROS_SVH
`define LGP_REGISTER_MACHINE_EXECUTOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RMX_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RMX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RMX_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define RMX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/rmx_pkg.sv =====
// ----------------------------------------------------------------------------
// rmx_pkg
// Shared types, constants and helpers of the register machine executor.
// ----------------------------------------------------------------------------
`default_nettype none

package rmx_pkg;

    localparam int POINTS_DEF = 64;
    localparam int REGS_DEF   = 8;

    localparam int S_TDATA_W = 48;  // dest, src_a, src_b, point, load value, pad
    localparam int S_TUSER_W = 3;   // op
    localparam int M_TDATA_W = 40;  // out_point, out_value, pad

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_EXP  = 3'd5,
        OP_LOG  = 3'd6,
        OP_READ = 3'd7
    } op_t;

    typedef struct packed {
        logic        done;
        logic        wr;
        logic [31:0] res;
    } alu_rsp_t;

    localparam logic signed [63:0] LOG2E_Q30 = 64'sd1549082005;
    localparam logic [29:0]        LN2_Q30   = 30'd744261118;
    localparam logic signed [63:0] SAT_HI    = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO    = -64'sd2147483648;
    localparam logic [31:0]        Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0]        Q_MIN     = 32'h8000_0000;

    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > SAT_HI)
            r = Q_MAX;
        else if (v < SAT_LO)
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // floor(2^32 / n) for n = 2 to 12, all ones for n = 1, zero otherwise
    function automatic logic [31:0] recip(input logic [3:0] n);
        logic [31:0] r;
        case (n)
            4'd1:    r = 32'hFFFF_FFFF;
            4'd2:    r = 32'h8000_0000;
            4'd3:    r = 32'h5555_5555;
            4'd4:    r = 32'h4000_0000;
            4'd5:    r = 32'h3333_3333;
            4'd6:    r = 32'h2AAA_AAAA;
            4'd7:    r = 32'h2492_4924;
            4'd8:    r = 32'h2000_0000;
            4'd9:    r = 32'h1C71_C71C;
            4'd10:   r = 32'h1999_9999;
            4'd11:   r = 32'h1745_D174;
            4'd12:   r = 32'h1555_5555;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rmx_bank.sv =====
// ----------------------------------------------------------------------------
// rmx_bank
// Register bank memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rmx_bank #(
    parameter int AW = 9
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [31:0]   rdata_a,
    output logic      [31:0]   rdata_b
);

    logic [31:0] mem [1 << AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rmx_alu.sv =====
// ----------------------------------------------------------------------------
// rmx_alu
// Multi-cycle Q16.16 unit: add, sub, mul, div, exp and log of one point.
// ----------------------------------------------------------------------------
`default_nettype none

module rmx_alu
    import rmx_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire op_t                op,
    input  wire logic signed [31:0] a_in,
    input  wire logic signed [31:0] b_in,
    output alu_rsp_t                rsp
);

    typedef enum logic [3:0] {
        A_IDLE, A_DONE, A_MUL, A_DIV, A_DIVF,
        A_EXP_K, A_EXP_U, A_EXP_M, A_EXP_R, A_EXP_C, A_EXP_F,
        A_LOG_SQ, A_LOG_M, A_LOG_F
    } astate_t;

    astate_t            state_reg;
    logic [31:0]        res_reg;
    logic               wr_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        prod_reg;
    logic               neg_reg;
    // divider
    logic [47:0]        dvd_reg;
    logic [47:0]        quo_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        dvs_reg;
    // exp
    logic signed [17:0] k_reg;
    logic [29:0]        u_reg;
    logic [30:0]        term_reg;
    logic [30:0]        v_reg;
    logic [32:0]        sum_reg;
    logic [3:0]         n_reg;
    // log
    logic [30:0]        mant_reg;
    logic [4:0]         m_reg;
    logic [29:0]        frac_reg;
    logic [64:0]        lp_reg;

    // leading one of a positive operand
    logic [4:0]  lead;
    logic [30:0] norm;
    always_comb
    begin
        lead = 5'd0;
        for (int i = 0; i < 31; i++)
        begin
            if (a_in[i])
                lead = 5'(i);
        end
        norm = a_in[30:0] << (5'd30 - lead);
    end

    // divider step
    logic [32:0] rem_sh;
    logic        ge;
    assign rem_sh = {rem_reg, dvd_reg[47]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    // series term correction
    logic [30:0] q0;
    logic [35:0] rr;
    logic [30:0] qc;
    always_comb
    begin
        q0 = prod_reg[62:32];
        rr = 36'(v_reg) - 36'(q0) * 36'(n_reg);
        qc = (rr >= 36'(n_reg)) ? q0 + 31'd1 : q0;
    end

    // log squaring step
    logic [61:0] sq;
    logic [31:0] sq_t;
    assign sq   = 62'(mant_reg) * 62'(mant_reg);
    assign sq_t = sq[61:30];

    // exp scaling
    logic signed [18:0] s19;
    logic [30:0]        sumc;
    logic [5:0]         sh6;
    logic [40:0]        rnd;
    logic [40:0]        scl;
    logic [31:0]        exp_res;
    always_comb
    begin
        s19  = 19'sd14 - 19'(k_reg);
        sumc = (sum_reg > 33'(Q_MAX)) ? Q_MAX[30:0] : sum_reg[30:0];
        sh6  = s19[5:0];
        rnd  = 41'd1 << (sh6 - 6'd1);
        scl  = (41'(sumc) + rnd) >> sh6;
        if (k_reg > 18'sd14)
            exp_res = Q_MAX;
        else if (s19 == 19'sd0)
            exp_res = 32'(sumc);
        else if (s19 >= 19'sd40)
            exp_res = 32'd0;
        else
            exp_res = scl[31:0];
    end

    // log finish
    logic [6:0]  e7;
    logic [35:0] l36;
    logic [35:0] mag;
    logic [65:0] lsum;
    logic [20:0] lr;
    always_comb
    begin
        e7   = 7'(m_reg) - 7'd16;
        l36  = {e7[5:0], frac_reg};
        mag  = l36[35] ? 36'd0 - l36 : l36;
        lsum = 66'(lp_reg) + (66'd1 << 43);
        lr   = lsum[64:44];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            case (state_reg)
                A_IDLE:
                begin
                    if (start)
                    begin
                        wr_reg <= 1'b1;
                        case (op)
                            OP_ADD:
                            begin
                                res_reg   <= sat64(64'(a_in) + 64'(b_in));
                                state_reg <= A_DONE;
                            end
                            OP_SUB:
                            begin
                                res_reg   <= sat64(64'(a_in) - 64'(b_in));
                                state_reg <= A_DONE;
                            end
                            OP_MUL:
                            begin
                                prod_reg  <= 64'(a_in) * 64'(b_in);
                                state_reg <= A_MUL;
                            end
                            OP_DIV:
                            begin
                                if (b_in == 32'sd0)
                                begin
                                    wr_reg    <= 1'b0;
                                    state_reg <= A_DONE;
                                end
                                else
                                begin
                                    neg_reg   <= a_in[31] ^ b_in[31];
                                    dvd_reg   <= {(a_in[31] ? 32'd0 - a_in : a_in), 16'd0};
                                    dvs_reg   <= b_in[31] ? 32'd0 - b_in : b_in;
                                    rem_reg   <= 32'd0;
                                    quo_reg   <= 48'd0;
                                    cnt_reg   <= 6'd47;
                                    state_reg <= A_DIV;
                                end
                            end
                            OP_EXP:
                            begin
                                prod_reg  <= 64'(a_in) * LOG2E_Q30;
                                state_reg <= A_EXP_K;
                            end
                            OP_LOG:
                            begin
                                if (a_in[31] || a_in == 32'sd0)
                                begin
                                    wr_reg    <= 1'b0;
                                    state_reg <= A_DONE;
                                end
                                else
                                begin
                                    m_reg     <= lead;
                                    mant_reg  <= norm;
                                    frac_reg  <= 30'd0;
                                    cnt_reg   <= 6'd29;
                                    state_reg <= A_LOG_SQ;
                                end
                            end
                            default:
                            begin
                                wr_reg    <= 1'b0;
                                state_reg <= A_DONE;
                            end
                        endcase
                    end
                end
                A_MUL:
                begin
                    res_reg   <= sat64($signed(prod_reg) >>> 16);
                    state_reg <= A_DONE;
                end
                A_DIV:
                begin
                    rem_reg <= ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
                    quo_reg <= {quo_reg[46:0], ge};
                    dvd_reg <= {dvd_reg[46:0], 1'b0};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                        state_reg <= A_DIVF;
                end
                A_DIVF:
                begin
                    if (!neg_reg)
                        res_reg <= (quo_reg > 48'h0000_7FFF_FFFF) ? Q_MAX : quo_reg[31:0];
                    else
                        res_reg <= (quo_reg > 48'h0000_8000_0000) ? Q_MIN
                                                                 : 32'd0 - quo_reg[31:0];
                    state_reg <= A_DONE;
                end
                A_EXP_K:
                begin
                    k_reg     <= $signed(prod_reg[63:46]);
                    prod_reg  <= 64'(prod_reg[45:16]) * 64'(LN2_Q30);
                    state_reg <= A_EXP_U;
                end
                A_EXP_U:
                begin
                    u_reg     <= prod_reg[59:30];
                    term_reg  <= 31'h4000_0000;
                    sum_reg   <= 33'h0_4000_0000;
                    n_reg     <= 4'd1;
                    state_reg <= A_EXP_M;
                end
                A_EXP_M:
                begin
                    prod_reg  <= 64'(term_reg) * 64'(u_reg);
                    state_reg <= A_EXP_R;
                end
                A_EXP_R:
                begin
                    v_reg     <= prod_reg[60:30];
                    prod_reg  <= 64'(prod_reg[60:30]) * 64'(recip(n_reg));
                    state_reg <= A_EXP_C;
                end
                A_EXP_C:
                begin
                    term_reg <= qc;
                    sum_reg  <= sum_reg + 33'(qc);
                    n_reg    <= n_reg + 4'd1;
                    if (n_reg == 4'd12)
                        state_reg <= A_EXP_F;
                    else
                        state_reg <= A_EXP_M;
                end
                A_EXP_F:
                begin
                    res_reg   <= exp_res;
                    state_reg <= A_DONE;
                end
                A_LOG_SQ:
                begin
                    mant_reg <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                    frac_reg <= {frac_reg[28:0], sq_t[31]};
                    cnt_reg  <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                        state_reg <= A_LOG_M;
                end
                A_LOG_M:
                begin
                    neg_reg   <= l36[35];
                    lp_reg    <= 65'(mag) * 65'(LN2_Q30);
                    state_reg <= A_LOG_F;
                end
                A_LOG_F:
                begin
                    res_reg   <= neg_reg ? 32'd0 - 32'(lr) : 32'(lr);
                    state_reg <= A_DONE;
                end
                A_DONE:
                begin
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = (state_reg == A_DONE);
    assign rsp.wr   = wr_reg;
    assign rsp.res  = res_reg;

endmodule

`default_nettype wire

// ===== rtl/lgp_register_machine_executor.sv =====
// ----------------------------------------------------------------------------
// lgp_register_machine_executor
// Register machine over a bank of sample points in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one instruction word per handshake, op on s_tuser.
//   Load fills all REGS registers of one point; an arithmetic op runs over
//   all POINTS points; read returns one word on the master stream m_*.
//   Words are taken one at a time: s_tready is high only while the
//   sequencer is idle. Per-item cost is set by the single bank write port
//   and the multi-cycle unit, one point at a time: a load writes the REGS
//   registers in turn, a read passes a data capture and an output step, and
//   an arithmetic op reads, starts the unit and waits on it for each point;
//   div on a zero divisor and log of a non-positive operand write nothing.
//   The read result sits in an output register, so a new word is taken
//   while m_tvalid waits on m_tready; a further read holds until it drains.
//   After reset the bank is swept to zero, one entry a cycle, over all its
//   2^(PW+RW) entries (512 by default) with s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lgp_register_machine_executor_macros.svh"

module lgp_register_machine_executor
    import rmx_pkg::*;
#(
    parameter int POINTS = POINTS_DEF,
    parameter int REGS   = REGS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [2:0] dest_reg, [5:3] src_a, [8:6] src_b, [14:9] point_index,
    // [46:15] load_value, [47] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] op
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [5:0] out_point, [37:6] out_value, [39:38] zero
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int PW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int RW = $clog2(REGS);
    localparam int AW = PW + RW;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_LOAD, S_AR_RD, S_AR_GO, S_AR_WAIT, S_RD_DATA, S_RD_OUT
    } state_t;

    // input word fields
    op_t         f_op;
    logic [2:0]  f_dest;
    logic [2:0]  f_src_a;
    logic [2:0]  f_src_b;
    logic [5:0]  f_point;
    logic [31:0] f_value;

    assign f_op    = op_t'(s_tuser);
    assign f_dest  = s_tdata[2:0];
    assign f_src_a = s_tdata[5:3];
    assign f_src_b = s_tdata[8:6];
    assign f_point = s_tdata[14:9];
    assign f_value = s_tdata[46:15];

    state_t        state_reg;
    logic [AW-1:0] clr_reg;
    logic [PW-1:0] pnt_reg;
    logic [RW-1:0] rsel_reg;
    logic [5:0]    lpt_reg;
    logic [2:0]    dst_reg;
    logic [2:0]    sa_reg;
    logic [2:0]    sb_reg;
    op_t           opr_reg;
    logic [31:0]   val_reg;
    logic          rd_ok_reg;
    logic          out_valid_reg;
    logic [39:0]   out_data_reg;

    logic accept;
    logic pt_ok;
    logic a_ok;
    logic b_ok;
    logic d_ok;
    assign accept = s_tvalid && s_tready;
    assign pt_ok  = 32'(f_point) < 32'(POINTS);
    assign a_ok   = 32'(f_src_a) < 32'(REGS);
    assign b_ok   = 32'(f_src_b) < 32'(REGS);
    assign d_ok   = 32'(f_dest) < 32'(REGS);

    // bank ports
    logic          bank_we;
    logic [AW-1:0] bank_waddr;
    logic [31:0]   bank_wdata;
    logic          bank_re;
    logic [AW-1:0] bank_raddr_a;
    logic [AW-1:0] bank_raddr_b;
    logic [31:0]   bank_rdata_a;
    logic [31:0]   bank_rdata_b;

    alu_rsp_t alu_rsp;

    // One access pattern per state; a point's write lands before the next
    // point's reads, and points never share an entry, so no forwarding.
    always_comb
    begin
        bank_we      = 1'b0;
        bank_waddr   = clr_reg;
        bank_wdata   = 32'd0;
        bank_re      = 1'b0;
        bank_raddr_a = {pnt_reg, RW'(sa_reg)};
        bank_raddr_b = {pnt_reg, RW'(sb_reg)};
        case (state_reg)
            S_CLR:
            begin
                bank_we = 1'b1;
            end
            S_IDLE:
            begin
                bank_re      = accept && (f_op == OP_READ);
                bank_raddr_a = {f_point[PW-1:0], RW'(f_src_a)};
            end
            S_LOAD:
            begin
                bank_we    = 1'b1;
                bank_waddr = {lpt_reg[PW-1:0], rsel_reg};
                bank_wdata = val_reg;
            end
            S_AR_RD:
            begin
                bank_re = 1'b1;
            end
            S_AR_WAIT:
            begin
                bank_we    = alu_rsp.done && alu_rsp.wr;
                bank_waddr = {pnt_reg, RW'(dst_reg)};
                bank_wdata = alu_rsp.res;
            end
            default:
            begin
                bank_we = 1'b0;
            end
        endcase
    end

    rmx_bank #(
        .AW (AW)
    ) u_bank (
        .clk     (clk),
        .we      (bank_we),
        .waddr   (bank_waddr),
        .wdata   (bank_wdata),
        .re      (bank_re),
        .raddr_a (bank_raddr_a),
        .raddr_b (bank_raddr_b),
        .rdata_a (bank_rdata_a),
        .rdata_b (bank_rdata_b)
    );

    rmx_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_AR_GO),
        .op    (opr_reg),
        .a_in  (bank_rdata_a),
        .b_in  (bank_rdata_b),
        .rsp   (alu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            pnt_reg       <= '0;
            rsel_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the output word once taken; the output step refills it
            if (m_tready && (state_reg != S_RD_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        lpt_reg <= f_point;
                        dst_reg <= f_dest;
                        sa_reg  <= f_src_a;
                        sb_reg  <= f_src_b;
                        opr_reg <= f_op;
                        val_reg <= f_value;
                        case (f_op)
                            OP_LOAD:
                            begin
                                rsel_reg <= '0;
                                if (pt_ok)
                                    state_reg <= S_LOAD;
                            end
                            OP_READ:
                            begin
                                rd_ok_reg <= pt_ok && a_ok;
                                state_reg <= S_RD_DATA;
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                            begin
                                pnt_reg <= '0;
                                if (d_ok && a_ok && b_ok)
                                    state_reg <= S_AR_RD;
                            end
                            default:
                            begin
                                pnt_reg <= '0;
                                if (d_ok && a_ok)
                                    state_reg <= S_AR_RD;
                            end
                        endcase
                    end
                end
                S_LOAD:
                begin
                    rsel_reg <= rsel_reg + RW'(1);
                    if (rsel_reg == RW'(REGS - 1))
                        state_reg <= S_IDLE;
                end
                S_AR_RD:
                begin
                    state_reg <= S_AR_GO;
                end
                S_AR_GO:
                begin
                    state_reg <= S_AR_WAIT;
                end
                S_AR_WAIT:
                begin
                    if (alu_rsp.done)
                    begin
                        if (pnt_reg == PW'(POINTS - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            pnt_reg   <= pnt_reg + PW'(1);
                            state_reg <= S_AR_RD;
                        end
                    end
                end
                S_RD_DATA:
                begin
                    // hold the read word until the output slot frees up
                    val_reg   <= rd_ok_reg ? bank_rdata_a : 32'd0;
                    state_reg <= S_RD_OUT;
                end
                S_RD_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {2'b00, val_reg, lpt_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // the bank is never written while words are being taken
    `RMX_ASSERT_IMPL(a_idle_no_write, clk, rst_n, state_reg == S_IDLE, !bank_we, "bank write while idle")
    // the unit only finishes while the sequencer waits on it
    `RMX_ASSERT_IMPL(a_done_in_wait, clk, rst_n, alu_rsp.done, state_reg == S_AR_WAIT, "unit done outside wait")
    // a read word moves straight to the data capture step
    `RMX_ASSERT_NEXT(a_read_capture, clk, rst_n, accept && (f_op == OP_READ), state_reg == S_RD_DATA, "read not captured")

endmodule

`default_nettype wire
